FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the bit error rate meter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside of reset.
`define BEM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define BEM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/bem_pkg.sv
// ----------------------------------------------------------------------------
// Bit error rate meter package
// Widths, constants, codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package bem_pkg;

   localparam int COUNT_WIDTH   = 48;
   localparam int LOG_FRAC_BITS = 10;

   localparam int BYTE_W    = 8;
   localparam int PCNT_W    = $clog2(BYTE_W + 1);
   localparam int LOG_W     = 15;
   localparam int MIN_ERR_W = 24;
   localparam int BPB_W     = 4;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 2;
   localparam int CMP_W     = (COUNT_WIDTH > MIN_ERR_W) ? COUNT_WIDTH : MIN_ERR_W;

   // Fixed-point log2 datapath.
   localparam int L2_FRAC    = 24;
   localparam int C_FRAC     = 30;
   localparam int C_W        = 29;
   localparam logic [C_W-1:0] LOG10_2_Q = C_W'(323228497);
   localparam int NORM_W     = 64;
   localparam int MANT_W     = 32;
   localparam int NORM_STEP  = 4;
   localparam int N_W        = $clog2(NORM_W);
   localparam int L2_W       = N_W + L2_FRAC;
   localparam int DIFF_W     = L2_W + 2;
   localparam int MAG_W      = DIFF_W - 1;
   localparam int PROD_W     = MAG_W + C_W;
   localparam int RSHIFT     = L2_FRAC + C_FRAC - LOG_FRAC_BITS;
   localparam int R_RAW_W    = PROD_W + 1 - RSHIFT;
   localparam int R_W        = (R_RAW_W > LOG_W + 1) ? R_RAW_W : LOG_W + 1;
   localparam int ITER_W     = $clog2(L2_FRAC);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic signed [LOG_W-1:0] OUT_MIN = {1'b1, {(LOG_W-1){1'b0}}};
   localparam logic signed [LOG_W-1:0] OUT_MAX = {1'b0, {(LOG_W-1){1'b1}}};

   localparam logic                    TEST_MODE_RESET  = 1'b0;
   localparam logic [MIN_ERR_W-1:0]    MIN_ERRORS_RESET = MIN_ERR_W'(100);
   localparam logic signed [LOG_W-1:0] BER_FLOOR_RESET  = -15'sd7168;
   localparam logic [BPB_W-1:0]        BPB_RESET        = BPB_W'(8);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEST_MODE,
      CSR_MIN_ERRORS,
      CSR_BER_FLOOR,
      CSR_BITS_PER_BYTE
   } csr_index_type;

   typedef enum logic {
      CMD_COMPARE,
      CMD_REPORT
   } cmd_type;

   // A report job always gives a result; a floor job gives one only when
   // the rate falls below the limit, and always returns a verdict.
   typedef enum logic {
      JOB_REPORT,
      JOB_FLOOR
   } job_kind_type;

   typedef struct packed {
      job_kind_type               kind;
      logic                       finished;
      logic [COUNT_WIDTH-1:0]     err_cnt;
      logic [COUNT_WIDTH-1:0]     byte_cnt;
      logic [BPB_W-1:0]           bpb;
      logic signed [LOG_W-1:0]    floor_lim;
   } job_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } verdict_type;

endpackage

FILE: hdl/bem_front.sv
// ----------------------------------------------------------------------------
// Bit error rate meter front end
// Holds configuration and counts, classifies each transfer and queues jobs.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bem_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic                         req_cmd,
   input  logic [bem_pkg::BYTE_W-1:0]   req_sent_byte,
   input  logic [bem_pkg::BYTE_W-1:0]   req_received_byte,
   input  logic                         csr_write,
   input  bem_pkg::csr_index_type       csr_index,
   input  logic [bem_pkg::CSR_W-1:0]    csr_wdata,
   output logic                         q_push,
   output bem_pkg::job_type             q_job,
   input  logic                         q_full,
   input  bem_pkg::verdict_type         verdict
);
   import bem_pkg::*;

   logic                    test_mode_ff, test_mode_in;
   logic [MIN_ERR_W-1:0]    min_errors_ff, min_errors_in;
   logic signed [LOG_W-1:0] ber_floor_ff, ber_floor_in;
   logic [BPB_W-1:0]        bpb_ff, bpb_in;
   logic [COUNT_WIDTH-1:0]  err_cnt_ff, err_cnt_in;
   logic [COUNT_WIDTH-1:0]  byte_cnt_ff, byte_cnt_in;
   logic                    done_ff, done_in;
   logic                    pending_ff, pending_in;

   logic                    accept;
   logic [PCNT_W-1:0]       pcnt;
   logic [COUNT_WIDTH:0]    err_sum;
   logic [COUNT_WIDTH-1:0]  err_inc;
   logic [COUNT_WIDTH-1:0]  byte_inc;
   logic                    at_min_old;
   logic                    at_min_new;

   function automatic logic [PCNT_W-1:0] popcount(input logic [BYTE_W-1:0] v);
      logic [PCNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         c = c + PCNT_W'(v[i]);
      end
      return c;
   endfunction

   // While a floor check is out at the back end, the next item waits for
   // its verdict, since that verdict may end the measurement.
   assign req_full = q_full || pending_ff;
   assign accept   = req_push && !req_full;

   always_comb begin
      pcnt       = popcount(req_sent_byte ^ req_received_byte);
      err_sum    = {1'b0, err_cnt_ff} + (COUNT_WIDTH+1)'(pcnt);
      err_inc    = err_sum[COUNT_WIDTH] ? COUNT_MAX : err_sum[COUNT_WIDTH-1:0];
      byte_inc   = (byte_cnt_ff == COUNT_MAX) ? byte_cnt_ff : byte_cnt_ff + 1'b1;
      at_min_old = CMP_W'(err_cnt_ff) >= CMP_W'(min_errors_ff);
      at_min_new = CMP_W'(err_inc) >= CMP_W'(min_errors_ff);
   end

   always_comb begin
      test_mode_in  = test_mode_ff;
      min_errors_in = min_errors_ff;
      ber_floor_in  = ber_floor_ff;
      bpb_in        = bpb_ff;
      err_cnt_in    = err_cnt_ff;
      byte_cnt_in   = byte_cnt_ff;
      done_in       = done_ff;
      pending_in    = pending_ff;
      q_push        = 1'b0;

      q_job.kind      = JOB_REPORT;
      q_job.finished  = 1'b0;
      q_job.err_cnt   = err_inc;
      q_job.byte_cnt  = byte_inc;
      q_job.bpb       = bpb_ff;
      q_job.floor_lim = ber_floor_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_TEST_MODE:     test_mode_in  = csr_wdata[0];
            CSR_MIN_ERRORS:    min_errors_in = csr_wdata[MIN_ERR_W-1:0];
            CSR_BER_FLOOR:     ber_floor_in  = $signed(csr_wdata[LOG_W-1:0]);
            CSR_BITS_PER_BYTE: bpb_in        = csr_wdata[BPB_W-1:0];
         endcase
      end

      if (accept) begin
         priority if (req_cmd == CMD_REPORT) begin
            // Report what has been counted so far, then start over.
            q_push         = 1'b1;
            q_job.err_cnt  = err_cnt_ff;
            q_job.byte_cnt = byte_cnt_ff;
            err_cnt_in     = '0;
            byte_cnt_in    = '0;
            done_in        = 1'b0;
         end else if (!test_mode_ff) begin
            q_push      = 1'b1;
            err_cnt_in  = err_inc;
            byte_cnt_in = byte_inc;
         end else if (done_ff || at_min_old) begin
            done_in = 1'b1;
         end else begin
            err_cnt_in  = err_inc;
            byte_cnt_in = byte_inc;
            priority if (at_min_new) begin
               q_push         = 1'b1;
               q_job.finished = 1'b1;
               done_in        = 1'b1;
            end else if (err_inc != '0) begin
               q_push     = 1'b1;
               q_job.kind = JOB_FLOOR;
               pending_in = 1'b1;
            end else begin
               q_push = 1'b0;
            end
         end
      end

      if (verdict.valid) begin
         pending_in = 1'b0;
         if (verdict.hit) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         test_mode_ff  <= TEST_MODE_RESET;
         min_errors_ff <= MIN_ERRORS_RESET;
         ber_floor_ff  <= BER_FLOOR_RESET;
         bpb_ff        <= BPB_RESET;
         err_cnt_ff    <= '0;
         byte_cnt_ff   <= '0;
         done_ff       <= 1'b0;
         pending_ff    <= 1'b0;
      end else begin
         test_mode_ff  <= test_mode_in;
         min_errors_ff <= min_errors_in;
         ber_floor_ff  <= ber_floor_in;
         bpb_ff        <= bpb_in;
         err_cnt_ff    <= err_cnt_in;
         byte_cnt_ff   <= byte_cnt_in;
         done_ff       <= done_in;
         pending_ff    <= pending_in;
      end
   end

   `BEM_ASSERT(a_verdict_pending, clock, reset, verdict.valid |-> pending_ff, "verdict without a pending floor check")

endmodule

FILE: hdl/bem_queue.sv
// ----------------------------------------------------------------------------
// Bit error rate meter job queue
// Short first-in first-out store of jobs between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bem_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bem_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output bem_pkg::job_type pop_data,
   output logic             empty
);
   import bem_pkg::*;

   job_type             slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   `BEM_ASSERT(a_no_underflow, clock, reset, pop |-> (cnt_ff != '0), "job queue read while empty")
   `BEM_ASSERT_NEXT(a_push_lands, clock, reset, push && !pop, cnt_ff != '0, "pushed job not held")

endmodule

FILE: hdl/bem_back.sv
// ----------------------------------------------------------------------------
// Bit error rate meter back end
// Evaluates log10 of the error rate with a shared log2 unit and holds the
// result register toward the output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bem_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bem_pkg::job_type              q_data,
   input  logic                          q_empty,
   output logic                          q_pop,
   output bem_pkg::verdict_type          verdict,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [bem_pkg::LOG_W-1:0] rsp_log_ber,
   output logic                          rsp_no_errors,
   output logic                          rsp_finished,
   output logic                          rsp_floor_reached
);
   import bem_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_SQR,
      S_ACC,
      S_ABS,
      S_MUL,
      S_ROUND,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      OP_ERR,
      OP_BYTE,
      OP_BPB
   } operand_type;

   localparam logic [PROD_W:0] RND_HALF = (PROD_W+1)'(1) << (RSHIFT - 1);

   state_type               state_ff, state_in;
   operand_type             opnd_ff, opnd_in;
   job_type                 job_ff, job_in;
   logic [NORM_W-1:0]       norm_ff, norm_in;
   logic [N_W-1:0]          n_ff, n_in;
   logic [MANT_W-1:0]       m_ff, m_in;
   logic [L2_FRAC-1:0]      f_ff, f_in;
   logic [ITER_W-1:0]       iter_ff, iter_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic                    neg_ff, neg_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic signed [LOG_W-1:0] res_ff, res_in;
   logic                    zero_ff, zero_in;

   logic                    out_valid_ff, out_valid_in;
   logic signed [LOG_W-1:0] out_log_ff, out_log_in;
   logic                    out_zero_ff, out_zero_in;
   logic                    out_fin_ff, out_fin_in;
   logic                    out_flr_ff, out_flr_in;

   logic [2*MANT_W-1:0]     sq_full;
   logic [MANT_W:0]         sq;
   logic [L2_W-1:0]         acc_l;
   logic [PROD_W:0]         rsum;
   logic [R_W-1:0]          r_val;
   logic [LOG_W-1:0]        r_lo;
   logic                    room;
   logic                    hit;

   assign rsp_empty         = !out_valid_ff;
   assign rsp_log_ber       = out_log_ff;
   assign rsp_no_errors     = out_zero_ff;
   assign rsp_finished      = out_fin_ff;
   assign rsp_floor_reached = out_flr_ff;

   always_comb begin
      sq_full = (2*MANT_W)'(m_ff) * (2*MANT_W)'(m_ff);
      sq      = sq_full[2*MANT_W-1:MANT_W-1];
      acc_l   = {n_ff, f_ff};
      rsum    = (PROD_W+1)'(prod_ff) + RND_HALF;
      r_val   = R_W'(rsum >> RSHIFT);
      r_lo    = r_val[LOG_W-1:0];
      room    = !out_valid_ff || rsp_pop;
      hit     = res_ff < job_ff.floor_lim;
   end

   always_comb begin
      state_in     = state_ff;
      opnd_in      = opnd_ff;
      job_in       = job_ff;
      norm_in      = norm_ff;
      n_in         = n_ff;
      m_in         = m_ff;
      f_in         = f_ff;
      iter_in      = iter_ff;
      diff_in      = diff_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      zero_in      = zero_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_log_in   = out_log_ff;
      out_zero_in  = out_zero_ff;
      out_fin_in   = out_fin_ff;
      out_flr_in   = out_flr_ff;
      q_pop        = 1'b0;
      verdict      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               job_in  = q_data;
               zero_in = 1'b0;
               diff_in = '0;
               opnd_in = OP_ERR;
               priority if (q_data.err_cnt == '0) begin
                  res_in   = OUT_MIN;
                  zero_in  = 1'b1;
                  state_in = S_EMIT;
               end else if (q_data.bpb == '0 || q_data.byte_cnt == '0) begin
                  res_in   = OUT_MAX;
                  state_in = S_EMIT;
               end else begin
                  norm_in  = NORM_W'(q_data.err_cnt) << (NORM_W - COUNT_WIDTH);
                  n_in     = N_W'(COUNT_WIDTH - 1);
                  state_in = S_NORM;
               end
            end
         end
         S_NORM: begin
            // Find the leading one a nibble at a time, then bit by bit.
            priority if (norm_ff[NORM_W-1 -: NORM_STEP] == '0) begin
               norm_in = norm_ff << NORM_STEP;
               n_in    = n_ff - N_W'(NORM_STEP);
            end else if (!norm_ff[NORM_W-1]) begin
               norm_in = norm_ff << 1;
               n_in    = n_ff - 1'b1;
            end else begin
               m_in     = norm_ff[NORM_W-1 -: MANT_W];
               f_in     = '0;
               iter_in  = '0;
               state_in = S_SQR;
            end
         end
         S_SQR: begin
            // Each square of the mantissa yields one fraction bit of log2.
            if (sq[MANT_W]) begin
               f_in = {f_ff[L2_FRAC-2:0], 1'b1};
               m_in = sq[MANT_W:1];
            end else begin
               f_in = {f_ff[L2_FRAC-2:0], 1'b0};
               m_in = sq[MANT_W-1:0];
            end
            if (iter_ff == ITER_W'(L2_FRAC - 1)) begin
               state_in = S_ACC;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         S_ACC: begin
            unique case (opnd_ff)
               OP_ERR: begin
                  diff_in  = diff_ff + $signed(DIFF_W'(acc_l));
                  norm_in  = NORM_W'(job_ff.byte_cnt) << (NORM_W - COUNT_WIDTH);
                  n_in     = N_W'(COUNT_WIDTH - 1);
                  opnd_in  = OP_BYTE;
                  state_in = S_NORM;
               end
               OP_BYTE: begin
                  diff_in  = diff_ff - $signed(DIFF_W'(acc_l));
                  norm_in  = NORM_W'(job_ff.bpb) << (NORM_W - BPB_W);
                  n_in     = N_W'(BPB_W - 1);
                  opnd_in  = OP_BPB;
                  state_in = S_NORM;
               end
               OP_BPB: begin
                  diff_in  = diff_ff - $signed(DIFF_W'(acc_l));
                  state_in = S_ABS;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_ABS: begin
            neg_in   = diff_ff[DIFF_W-1];
            mag_in   = diff_ff[DIFF_W-1] ? MAG_W'(-diff_ff) : MAG_W'(diff_ff);
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(LOG10_2_Q);
            state_in = S_ROUND;
         end
         S_ROUND: begin
            // Round half away from zero on the magnitude, then saturate.
            if (neg_ff) begin
               res_in = (r_val > R_W'(16384)) ? OUT_MIN : $signed(LOG_W'(0) - r_lo);
            end else begin
               res_in = (r_val > R_W'(16383)) ? OUT_MAX : $signed(r_lo);
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            unique case (job_ff.kind)
               JOB_REPORT: begin
                  if (room) begin
                     out_valid_in = 1'b1;
                     out_log_in   = res_ff;
                     out_zero_in  = zero_ff;
                     out_fin_in   = job_ff.finished;
                     out_flr_in   = 1'b0;
                     state_in     = S_IDLE;
                  end
               end
               JOB_FLOOR: begin
                  if (!hit) begin
                     verdict.valid = 1'b1;
                     state_in      = S_IDLE;
                  end else if (room) begin
                     verdict.valid = 1'b1;
                     verdict.hit   = 1'b1;
                     out_valid_in  = 1'b1;
                     out_log_in    = job_ff.floor_lim;
                     out_zero_in   = 1'b0;
                     out_fin_in    = 1'b1;
                     out_flr_in    = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      opnd_ff     <= opnd_in;
      job_ff      <= job_in;
      norm_ff     <= norm_in;
      n_ff        <= n_in;
      m_ff        <= m_in;
      f_ff        <= f_in;
      iter_ff     <= iter_in;
      diff_ff     <= diff_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      res_ff      <= res_in;
      zero_ff     <= zero_in;
      out_log_ff  <= out_log_in;
      out_zero_ff <= out_zero_in;
      out_fin_ff  <= out_fin_in;
      out_flr_ff  <= out_flr_in;
   end

   `BEM_ASSERT(a_iter_range, clock, reset, (state_ff == S_SQR) |-> (iter_ff < ITER_W'(L2_FRAC)), "squaring step count out of range")
   `BEM_ASSERT(a_verdict_kind, clock, reset, verdict.valid |-> (job_ff.kind == JOB_FLOOR), "verdict for a job that is not a floor check")

endmodule

FILE: hdl/bit_error_rate_meter.sv
// ----------------------------------------------------------------------------
// Bit error rate meter
// Counts bit errors between two byte streams and reports log10 of the rate.
// ----------------------------------------------------------------------------
// Input channel: a transfer of req_cmd and a byte pair is taken at an edge
// with req_push high and req_full low. A compare adds the popcount of the XOR
// to the error count and one to the byte count; a report returns the current
// value, then clears both counts. Result channel: the oldest result (signed
// Q5.10 rsp_log_ber and flags) shows while rsp_empty is low, taken with rsp_pop.
// Timing: the front end takes one item per cycle while req_full is low, into
// a two-entry job queue. The back end forms three log2 values with one shared
// unit, each by a leading-one search, a squaring per fraction bit and an add,
// then takes the magnitude, multiplies, rounds and emits the result; it takes
// a new job only once it is through with the last one. A zero-error or
// zero-denominator report skips the log and goes straight to the emit state.
// Items that give no result and need no log are not queued. A test-mode floor
// check holds req_full high until the back end decides. A stalled receiver
// holds the back end, the queue fills and req_full rises. Reset is synchronous
// and clears counts, queue and output; the registers take their default values.
// ----------------------------------------------------------------------------
module bit_error_rate_meter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_cmd,
   input  logic [bem_pkg::BYTE_W-1:0]        req_sent_byte,
   input  logic [bem_pkg::BYTE_W-1:0]        req_received_byte,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic signed [bem_pkg::LOG_W-1:0]  rsp_log_ber,
   output logic                              rsp_no_errors,
   output logic                              rsp_finished,
   output logic                              rsp_floor_reached,
   input  logic                              csr_write,
   input  bem_pkg::csr_index_type            csr_index,
   input  logic [bem_pkg::CSR_W-1:0]         csr_wdata
);
   import bem_pkg::*;

   // Jobs from the front end to the back end.
   logic        q_push;
   job_type     q_job;
   logic        q_full;
   logic        q_pop;
   job_type     q_data;
   logic        q_empty;

   // Outcome of a test-mode floor check, returned to the front end.
   verdict_type verdict;

   bem_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_sent_byte     (req_sent_byte),
      .req_received_byte (req_received_byte),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .q_push            (q_push),
      .q_job             (q_job),
      .q_full            (q_full),
      .verdict           (verdict)
   );

   bem_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   bem_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_data            (q_data),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .verdict           (verdict),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_log_ber       (rsp_log_ber),
      .rsp_no_errors     (rsp_no_errors),
      .rsp_finished      (rsp_finished),
      .rsp_floor_reached (rsp_floor_reached)
   );

endmodule

FILE: sim/bit_error_rate_meter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bit error rate meter testbench
// Drives byte pairs and report commands into the meter under several register
// settings, predicts each result in a bit-exact model of the log10 datapath
// and compares every result transfer field by field against the prediction.
// ----------------------------------------------------------------------------
module bit_error_rate_meter_tb;

   import bem_pkg::*;

   // Run limits. The settle time leaves room for one floor check in the log
   // unit that gives no result.
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 300;
   localparam int ITEM_TARGET   = 750;
   localparam int TEST_CAP      = 120;
   localparam int NUM_DIRECTED  = 37;

   // Fixed-point constants of the log10 computation.
   localparam int              Q_FRAC      = 24;
   localparam longint unsigned LOG10_OF_2  = 64'd323228497;
   localparam int              ROUND_SHIFT = Q_FRAC + 30 - LOG_FRAC_BITS;

   localparam logic signed [LOG_W-1:0] LOG_LOWEST  = -15'sd16384;
   localparam logic signed [LOG_W-1:0] LOG_HIGHEST = 15'sd16383;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_CEILING = '1;

   typedef struct packed {
      logic signed [LOG_W-1:0] log_ber;
      logic                    no_errors;
      logic                    finished;
      logic                    floor_reached;
   } ber_result_type;

   typedef enum logic {
      ROW_WRITE,
      ROW_ITEM
   } row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      csr_index_type        reg_index;
      logic [CSR_W-1:0]     reg_value;
      cmd_type              cmd;
      logic [BYTE_W-1:0]    sent;
      logic [BYTE_W-1:0]    received;
      logic                 pinned;
      ber_result_type       want;
   } stim_row_type;

   // Results that can be read straight off the behavior.
   localparam ber_result_type RES_NONE       = '0;
   localparam ber_result_type RES_NO_ERRORS  = '{LOG_LOWEST, 1'b1, 1'b0, 1'b0};
   localparam ber_result_type RES_UNITY      = '{15'sd0, 1'b0, 1'b0, 1'b0};
   localparam ber_result_type RES_CEILING    = '{LOG_HIGHEST, 1'b0, 1'b0, 1'b0};
   localparam ber_result_type RES_FLOOR_ZERO = '{15'sd0, 1'b0, 1'b1, 1'b1};

   logic clock = 1'b0;
   logic reset;

   logic                    req_push;
   logic                    req_full;
   cmd_type                 req_cmd;
   logic [BYTE_W-1:0]       req_sent_byte;
   logic [BYTE_W-1:0]       req_received_byte;
   logic                    rsp_empty;
   logic                    rsp_pop;
   logic signed [LOG_W-1:0] rsp_log_ber;
   logic                    rsp_no_errors;
   logic                    rsp_finished;
   logic                    rsp_floor_reached;
   logic                    csr_write;
   csr_index_type           csr_index;
   logic [CSR_W-1:0]        csr_wdata;

   // Shadow copy of the meter: registers, counts and the end-of-test flag.
   logic                    cfg_test_mode;
   logic [MIN_ERR_W-1:0]    cfg_min_errors;
   logic signed [LOG_W-1:0] cfg_ber_floor;
   logic [BPB_W-1:0]        cfg_bits_per_byte;
   logic [COUNT_WIDTH-1:0]  err_total;
   logic [COUNT_WIDTH-1:0]  byte_total;
   logic                    meas_done;

   ber_result_type pending_results[$];
   stim_row_type   directed_rows[NUM_DIRECTED];

   // A directed row may carry its own expected result.
   logic           row_pinned;
   ber_result_type row_want;

   logic idling;
   int   mismatch_count;
   int   useful_items;
   int   cycle_count;

   bit_error_rate_meter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_sent_byte     (req_sent_byte),
      .req_received_byte (req_received_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_log_ber       (rsp_log_ber),
      .rsp_no_errors     (rsp_no_errors),
      .rsp_finished      (rsp_finished),
      .rsp_floor_reached (rsp_floor_reached),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   // log2 of a nonzero count with 24 fraction bits. The integer part is the
   // position of the leading one; each fraction bit comes from squaring a
   // 1.31 mantissa and checking whether the square has reached two.
   function automatic longint log2_q24(input logic [63:0] x);
      int                lead;
      logic [63:0]       mant;
      logic [Q_FRAC-1:0] frac;
      lead = 0;
      for (int b = 0; b < 64; b++)
         if (x[b]) lead = b;
      mant = (x << (63 - lead)) >> 32;
      frac = '0;
      for (int i = 0; i < Q_FRAC; i++) begin
         mant = (mant * mant) >> 31;
         frac = {frac[Q_FRAC-2:0], 1'b0};
         if (mant[32]) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return (longint'(lead) << Q_FRAC) | longint'(frac);
   endfunction

   // log10 of errors / (bytes * bits_per_byte) from the shadow counts, rounded
   // half away from zero and saturated to the output range.
   function automatic ber_result_type rate_now();
      ber_result_type  res;
      longint          diff;
      longint          value;
      longint unsigned mag;
      longint unsigned rounded;
      res = '0;
      if (err_total == 0) begin
         res.log_ber   = LOG_LOWEST;
         res.no_errors = 1'b1;
         return res;
      end
      if (cfg_bits_per_byte == 0 || byte_total == 0) begin
         res.log_ber = LOG_HIGHEST;
         return res;
      end
      diff = log2_q24(64'(err_total)) - log2_q24(64'(byte_total))
           - log2_q24(64'(cfg_bits_per_byte));
      mag = (diff < 0) ? -diff : diff;
      rounded = (mag * LOG10_OF_2 + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      if (rounded > 64'd32768) rounded = 64'd32768;
      value = (diff < 0) ? -longint'(rounded) : longint'(rounded);
      if (value < -16384) value = -16384;
      if (value > 16383) value = 16383;
      res.log_ber = LOG_W'(value);
      return res;
   endfunction

   // Both counts stop at their maximum instead of wrapping.
   task automatic tally_pair(input logic [BYTE_W-1:0] sent,
                             input logic [BYTE_W-1:0] received);
      logic [COUNT_WIDTH-1:0] flips;
      flips = COUNT_WIDTH'($countones(sent ^ received));
      err_total = (err_total > COUNT_CEILING - flips) ? COUNT_CEILING : err_total + flips;
      if (byte_total != COUNT_CEILING) byte_total = byte_total + 1'b1;
   endtask

   // Advances the shadow state by one accepted transfer and tells whether a
   // result is due, and whether the meter drops the pair unseen.
   task automatic predict_transfer(input cmd_type cmd,
                                   input logic [BYTE_W-1:0] sent,
                                   input logic [BYTE_W-1:0] received,
                                   output logic has_res,
                                   output ber_result_type res,
                                   output logic ignored);
      has_res = 1'b0;
      ignored = 1'b0;
      res     = '0;
      if (cmd == CMD_REPORT) begin
         // A report gives the value as it stands, then starts a new count.
         res        = rate_now();
         has_res    = 1'b1;
         err_total  = '0;
         byte_total = '0;
         meas_done  = 1'b0;
      end else if (!cfg_test_mode) begin
         tally_pair(sent, received);
         res     = rate_now();
         has_res = 1'b1;
      end else if (meas_done || err_total >= cfg_min_errors) begin
         // The test has already ended, possibly by counts left over from
         // streaming; the pair is dropped.
         meas_done = 1'b1;
         ignored   = 1'b1;
      end else begin
         tally_pair(sent, received);
         res = rate_now();
         if (err_total >= cfg_min_errors) begin
            meas_done    = 1'b1;
            res.finished = 1'b1;
            has_res      = 1'b1;
         end else if (err_total != 0 && res.log_ber < cfg_ber_floor) begin
            // Ended early: the limit itself is reported, not the rate.
            meas_done = 1'b1;
            res       = '{cfg_ber_floor, 1'b0, 1'b1, 1'b1};
            has_res   = 1'b1;
         end
      end
   endtask

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. The result check
   // runs before the prediction so that an item accepted at the same edge
   // cannot be matched against its own result.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      ber_result_type got;
      ber_result_type want;
      ber_result_type res;
      logic           has_res;
      logic           ignored;
      if (reset) begin
         cfg_test_mode     = 1'b0;
         cfg_min_errors    = MIN_ERR_W'(100);
         cfg_ber_floor     = -15'sd7168;
         cfg_bits_per_byte = BPB_W'(8);
         err_total         = '0;
         byte_total        = '0;
         meas_done         = 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = '{rsp_log_ber, rsp_no_errors, rsp_finished, rsp_floor_reached};
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result, log_ber", longint'(got.log_ber), 0);
            end else begin
               want = pending_results.pop_front();
               if (got.log_ber !== want.log_ber)
                  report_mismatch("log_ber", longint'(got.log_ber), longint'(want.log_ber));
               if (got.no_errors !== want.no_errors)
                  report_mismatch("no_errors", got.no_errors, want.no_errors);
               if (got.finished !== want.finished)
                  report_mismatch("finished", got.finished, want.finished);
               if (got.floor_reached !== want.floor_reached)
                  report_mismatch("floor_reached", got.floor_reached, want.floor_reached);
            end
         end
         if (csr_write) begin
            case (csr_index)
               CSR_TEST_MODE:     cfg_test_mode     = csr_wdata[0];
               CSR_MIN_ERRORS:    cfg_min_errors    = csr_wdata[MIN_ERR_W-1:0];
               CSR_BER_FLOOR:     cfg_ber_floor     = csr_wdata[LOG_W-1:0];
               CSR_BITS_PER_BYTE: cfg_bits_per_byte = csr_wdata[BPB_W-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            predict_transfer(req_cmd, req_sent_byte, req_received_byte, has_res, res,
                             ignored);
            if (has_res) pending_results.push_back(row_pinned ? row_want : res);
            if (!ignored) useful_items++;
         end
      end
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bit_error_rate_meter test failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers. Inputs change only at the falling edge, and every
   // helper both starts and returns at a falling edge.
   // ---------------------------------------------------------------------

   // Mostly no pause; now and then a short one, rarely a long one.
   function automatic int idle_gap();
      if (!idling || $urandom_range(3) != 0) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(20, 60);
      return $urandom_range(1, 3);
   endfunction

   // Received byte for a given sent byte: clean with the given percentage,
   // otherwise inverted, one bit flipped or random.
   function automatic logic [BYTE_W-1:0] corrupt(input logic [BYTE_W-1:0] sent,
                                                 input int unsigned clean_pct);
      if ($urandom_range(99) < clean_pct) return sent;
      case ($urandom_range(3))
         0:       return ~sent;
         1:       return sent ^ (8'h01 << $urandom_range(7));
         default: return BYTE_W'($urandom);
      endcase
   endfunction

   // Register data with stray bits above the register width now and then;
   // the meter keeps only the low bits.
   function automatic logic [CSR_W-1:0] with_stray_bits(input logic [CSR_W-1:0] value,
                                                        input int width);
      logic [CSR_W-1:0] mask;
      mask = (CSR_W'(1) << width) - 1'b1;
      if ($urandom_range(3) != 0) return value & mask;
      return (value & mask) | (CSR_W'($urandom) & ~mask);
   endfunction

   // Holds the transfer until it is taken. On return push may still be high
   // with the old fields, so the caller sends the next item or lowers push
   // before the next rising edge.
   task automatic send_item(input cmd_type cmd, input logic [BYTE_W-1:0] sent,
                            input logic [BYTE_W-1:0] received);
      int gap;
      req_push          = 1'b1;
      req_cmd           = cmd;
      req_sent_byte     = sent;
      req_received_byte = received;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      gap = idle_gap();
      if (gap != 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Waits until every expected result has been taken, then lets a possible
   // floor check without a result finish before anything else happens.
   task automatic settle();
      req_push = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_W-1:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // The receiver: pop stays high except for random pauses.
   initial begin
      int hold;
      rsp_pop = 1'b0;
      hold    = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_pop = 1'b0;
            hold--;
         end else begin
            rsp_pop = 1'b1;
            hold    = idle_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [BYTE_W-1:0] sent;
      logic              test_phase;
      int unsigned       clean_pct;
      int                floor_value;
      int                n;

      reset             = 1'b1;
      req_push          = 1'b0;
      req_cmd           = CMD_COMPARE;
      req_sent_byte     = '0;
      req_received_byte = '0;
      csr_write         = 1'b0;
      csr_index         = CSR_TEST_MODE;
      csr_wdata         = '0;
      row_pinned        = 1'b0;
      row_want          = RES_NONE;
      idling            = 1'b1;
      mismatch_count    = 0;
      useful_items      = 0;
      cycle_count       = 0;

      // Directed part. It starts from the reset register values: streaming,
      // 8 bits per byte, 100 errors to end a test, limit -7168.
      directed_rows = '{
         // An empty count right after reset saturates low.
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'h00, 8'h00, 1'b1,
           RES_NO_ERRORS},
         // Every bit wrong in the first byte: the rate is exactly one.
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h00, 8'hFF, 1'b1,
           RES_UNITY},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'hFF, 8'hFF, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'hAA, 8'h55, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h80, 8'h00, 1'b0,
           RES_NONE},
         // The byte fields of a report are don't-care.
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'hA5, 8'h3C, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'hFF, 8'h00, 1'b1,
           RES_NO_ERRORS},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h5A, 8'h5A, 1'b1,
           RES_NO_ERRORS},
         // One bit per byte: the rate can exceed one and the log goes positive.
         '{ROW_WRITE, CSR_BITS_PER_BYTE, 24'd1,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'h00, 8'h00, 1'b1,
           RES_NO_ERRORS},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h00, 8'hFF, 1'b0,
           RES_NONE},
         // Zero bits per byte with errors present saturates high.
         '{ROW_WRITE, CSR_BITS_PER_BYTE, 24'd0,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h0F, 8'h00, 1'b1,
           RES_CEILING},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'h00, 8'h00, 1'b1,
           RES_CEILING},
         // Test mode ended by the error count, then a dropped pair.
         '{ROW_WRITE, CSR_BITS_PER_BYTE, 24'd8,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_WRITE, CSR_TEST_MODE,     24'd1,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_WRITE, CSR_MIN_ERRORS,    24'd1,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h33, 8'h33, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h01, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'hFF, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'h00, 8'h00, 1'b0,
           RES_NONE},
         // Test mode ended by the limit: the limit of zero is reported.
         '{ROW_WRITE, CSR_MIN_ERRORS,    24'hFFFFFF, CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_WRITE, CSR_BER_FLOOR,     24'h000000, CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h01, 8'h00, 1'b1,
           RES_FLOOR_ZERO},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h00, 8'hFF, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'h00, 8'h00, 1'b0,
           RES_NONE},
         // Lowest limit and highest count: the test never ends by itself.
         '{ROW_WRITE, CSR_BER_FLOOR,     24'h004000, CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'hFF, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h00, 8'hFF, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'h00, 8'h00, 1'b0,
           RES_NONE},
         // Counts from streaming already at the minimum when test mode starts.
         '{ROW_WRITE, CSR_TEST_MODE,     24'd0,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h00, 8'hFF, 1'b0,
           RES_NONE},
         '{ROW_WRITE, CSR_TEST_MODE,     24'd1,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_WRITE, CSR_MIN_ERRORS,    24'd1,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_COMPARE, 8'h12, 8'h34, 1'b0,
           RES_NONE},
         '{ROW_ITEM,  CSR_TEST_MODE,     24'h0,      CMD_REPORT,  8'h00, 8'h00, 1'b0,
           RES_NONE},
         '{ROW_WRITE, CSR_TEST_MODE,     24'd0,      CMD_COMPARE, 8'h00, 8'h00, 1'b0,
           RES_NONE}
      };

      repeat (7) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            settle();
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            row_pinned = directed_rows[i].pinned;
            row_want   = directed_rows[i].want;
            send_item(directed_rows[i].cmd, directed_rows[i].sent,
                      directed_rows[i].received);
         end
      end
      row_pinned = 1'b0;

      // Random part: phases of one register setting each, picked at random
      // between streaming and test mode. Counts carry over from phase to
      // phase unless a report clears them, which also exercises a test that
      // is over before it starts.
      while (useful_items < ITEM_TARGET) begin
         settle();
         idling     = ($urandom_range(3) != 0);
         test_phase = $urandom_range(1);
         case ($urandom_range(5))
            0:       floor_value = -16384;
            1:       floor_value = 0;
            default: floor_value = -int'($urandom_range(2500));
         endcase
         write_register(CSR_TEST_MODE, with_stray_bits(CSR_W'(test_phase), 1));
         case ($urandom_range(9))
            0:       write_register(CSR_MIN_ERRORS, 24'hFFFFFF);
            1:       write_register(CSR_MIN_ERRORS, 24'd1);
            default: write_register(CSR_MIN_ERRORS, CSR_W'($urandom_range(2, 40)));
         endcase
         write_register(CSR_BER_FLOOR, with_stray_bits(CSR_W'(floor_value), LOG_W));
         case ($urandom_range(9))
            0:       write_register(CSR_BITS_PER_BYTE, with_stray_bits(24'd0, BPB_W));
            1, 2, 3: write_register(CSR_BITS_PER_BYTE,
                                    with_stray_bits(CSR_W'($urandom_range(1, 7)), BPB_W));
            default: write_register(CSR_BITS_PER_BYTE, with_stray_bits(24'd8, BPB_W));
         endcase

         if (!test_phase) begin
            clean_pct = $urandom_range(60);
            repeat ($urandom_range(20, 60)) begin
               sent = BYTE_W'($urandom);
               if ($urandom_range(11) == 0)
                  send_item(CMD_REPORT, sent, BYTE_W'($urandom));
               else
                  send_item(CMD_COMPARE, sent, corrupt(sent, clean_pct));
            end
         end else begin
            // A well-formed test: clear, compare until the meter ends the test
            // or TEST_CAP is reached, send up to two pairs it must drop, then
            // report. Sometimes the clear is skipped or a report cuts in midway.
            clean_pct = $urandom_range(50, 98);
            if ($urandom_range(3) != 0) send_item(CMD_REPORT, 8'h00, 8'h00);
            n = 0;
            while (!meas_done && n < TEST_CAP) begin
               sent = BYTE_W'($urandom);
               if ($urandom_range(40) == 0)
                  send_item(CMD_REPORT, sent, BYTE_W'($urandom));
               else
                  send_item(CMD_COMPARE, sent, corrupt(sent, clean_pct));
               n++;
            end
            repeat ($urandom_range(2)) begin
               sent = BYTE_W'($urandom);
               send_item(CMD_COMPARE, sent, corrupt(sent, 0));
            end
            send_item(CMD_REPORT, BYTE_W'($urandom), BYTE_W'($urandom));
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("bit_error_rate_meter test passed");
      end else begin
         $display("bit_error_rate_meter test failed");
      end
      $finish;
   end

endmodule
